### rtl/pisc_pkg.sv
// ============================================================================
// pisc_pkg: shared types and constants of the PI speed controller
// Holds the configuration record, register indexes, the sequencer states and
// the fixed-point constants used by the speed and control arithmetic.
// ============================================================================
package pisc_pkg;

    localparam int PWM_BITS_DEF = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int DRIVE_W    = 10;
    localparam int SPEED_W    = 16;
    localparam int TIME_W     = 32;
    localparam int INTEG_W    = 28;
    localparam int ERR_W      = 18;
    localparam int MUL_W      = 22;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = 43;

    // The rpm product divided by 15360 is a shift by 10 and a division by 15,
    // the latter done as a multiply by ceil(2^24 / 15) and a shift by 24.
    localparam int          RPM_SHIFT  = 10;
    localparam logic [20:0] DIV15_RECIP = 21'd1118482;
    localparam int          DIV15_SHIFT = 24;
    localparam logic [23:0] SPEED_SAT_X = 24'd983040;

    localparam logic [15:0] RST_KP        = 16'd461;
    localparam logic [15:0] RST_KI_DT     = 16'd786;
    localparam logic [9:0]  RST_ILIMIT    = 10'd400;
    localparam logic [9:0]  RST_PWM_MAX   = 10'd1023;
    localparam logic [9:0]  RST_PWM_MIN   = 10'd300;
    localparam logic [9:0]  RST_PERIOD    = 10'd20;
    localparam logic [9:0]  RST_STOP_THR  = 10'd10;
    localparam logic [17:0] RST_WHEEL_CIRC = 18'd36191;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP        = 3'd0,
        CFG_KI_DT     = 3'd1,
        CFG_ILIMIT    = 3'd2,
        CFG_PWM_MAX   = 3'd3,
        CFG_PWM_MIN   = 3'd4,
        CFG_PERIOD    = 3'd5,
        CFG_STOP_THR  = 3'd6,
        CFG_WHEEL_CIRC = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] kp_q8;
        logic [15:0] ki_dt_q16;
        logic [9:0]  iterm_limit;
        logic [9:0]  pwm_max;
        logic [9:0]  stall_floor;
        logic [9:0]  period_ms;
        logic [9:0]  stop_threshold;
        logic [17:0] wheel_circ_q8;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_SPD,
        S_MUL_DIV,
        S_SPEED,
        S_MUL_KI,
        S_MUL_KP,
        S_SUM,
        S_FINISH,
        S_EMIT
    } t_state;

endpackage

### rtl/pisc_cfg_regs.sv
// ============================================================================
// pisc_cfg_regs: configuration register file
// Eight write-only registers loaded from the configuration channel.
// ============================================================================
module pisc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [pisc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pisc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output pisc_pkg::t_cfg                      o_cfg
);

    pisc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_q8          <= pisc_pkg::RST_KP;
            r_cfg.ki_dt_q16      <= pisc_pkg::RST_KI_DT;
            r_cfg.iterm_limit    <= pisc_pkg::RST_ILIMIT;
            r_cfg.pwm_max        <= pisc_pkg::RST_PWM_MAX;
            r_cfg.stall_floor    <= pisc_pkg::RST_PWM_MIN;
            r_cfg.period_ms      <= pisc_pkg::RST_PERIOD;
            r_cfg.stop_threshold <= pisc_pkg::RST_STOP_THR;
            r_cfg.wheel_circ_q8  <= pisc_pkg::RST_WHEEL_CIRC;
        end else if (i_cfg_valid) begin
            case (pisc_pkg::t_cfg_idx'(i_cfg_index))
                pisc_pkg::CFG_KP:         r_cfg.kp_q8          <= i_cfg_data[15:0];
                pisc_pkg::CFG_KI_DT:      r_cfg.ki_dt_q16      <= i_cfg_data[15:0];
                pisc_pkg::CFG_ILIMIT:     r_cfg.iterm_limit    <= i_cfg_data[9:0];
                pisc_pkg::CFG_PWM_MAX:    r_cfg.pwm_max        <= i_cfg_data[9:0];
                pisc_pkg::CFG_PWM_MIN:    r_cfg.stall_floor    <= i_cfg_data[9:0];
                pisc_pkg::CFG_PERIOD:     r_cfg.period_ms      <= i_cfg_data[9:0];
                pisc_pkg::CFG_STOP_THR:   r_cfg.stop_threshold <= i_cfg_data[9:0];
                pisc_pkg::CFG_WHEEL_CIRC: r_cfg.wheel_circ_q8  <= i_cfg_data[17:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/pisc_mul.sv
// ============================================================================
// pisc_mul: shared signed multiplier
// One registered signed multiplier that serves every product of an update.
// ============================================================================
module pisc_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [pisc_pkg::MUL_W-1:0]    i_a,
    input  logic signed [pisc_pkg::MUL_W-1:0]    i_b,
    output logic signed [pisc_pkg::PROD_W-1:0]   o_prod
);

    logic signed [pisc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/pi_speed_controller.sv
// ============================================================================
// pi_speed_controller: PI wheel-speed controller with anti-windup
// Scheduled PI update of a motor drive value from a speed target and a
// measured wheel rpm, in fixed point, built around one shared multiplier.
// ============================================================================
// Input channel (i_in_valid / o_in_stall) takes one sample: a function code,
// a millisecond timestamp, a signed target speed and the wheel rpm. Every
// sample produces exactly one result on the output channel (o_out_valid /
// i_out_stall): the last measured speed, the drive value now applied and a
// flag that tells whether this sample wrote a new drive value.
// A sample that is not due, carries a negative target or clears the
// integrator goes from the check state straight to the emit state; a full
// control step also walks the speed, sum and finish states. The sequencer
// walks four products (rpm times circumference, division by 15, integral
// term, proportional term) through the single multiplier, and o_in_stall
// stays high until the result is loaded, so no new sample enters before then.
// The result sits in an output register; the next sample is taken while it
// waits, and its own result is held back while the receiver stalls.
// Reset restores the default configuration, clears the integrator, schedule
// mark, last speed and last drive, and empties the output register.
// Configuration writes are always taken (o_cfg_ready is high).
// ============================================================================
module pi_speed_controller #(
    parameter int PWM_BITS = pisc_pkg::PWM_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic [31:0]                        i_now_ms,
    input  logic signed [15:0]                 i_target_speed_mm_s,
    input  logic [15:0]                        i_wheel_rpm,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [15:0]                        o_measured_speed_mm_s,
    output logic [PWM_BITS-1:0]                o_drive_pwm,
    output logic                               o_drive_written,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pisc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pisc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pisc_pkg::t_cfg   w_cfg;
    pisc_pkg::t_state r_state, n_state;

    logic                                    r_func, n_func;
    logic [31:0]                             r_now, n_now;
    logic [15:0]                             r_target, n_target;
    logic [15:0]                             r_rpm, n_rpm;
    logic [31:0]                             r_next_due, n_next_due;
    logic signed [pisc_pkg::INTEG_W-1:0]     r_integ, n_integ;
    logic signed [pisc_pkg::INTEG_W-1:0]     r_integ_new, n_integ_new;
    logic [15:0]                             r_last_speed, n_last_speed;
    logic [pisc_pkg::DRIVE_W-1:0]            r_last_drive, n_last_drive;
    logic                                    r_sat, n_sat;
    logic signed [pisc_pkg::ERR_W-1:0]       r_err, n_err;
    logic signed [pisc_pkg::SUM_W-1:0]       r_sum, n_sum;
    logic                                    r_written, n_written;
    logic                                    r_out_valid, n_out_valid;
    logic [15:0]                             r_out_speed, n_out_speed;
    logic [pisc_pkg::DRIVE_W-1:0]            r_out_drive, n_out_drive;
    logic                                    r_out_written, n_out_written;

    logic                                    w_mul_en;
    logic signed [pisc_pkg::MUL_W-1:0]       w_mul_a, w_mul_b;
    logic signed [pisc_pkg::PROD_W-1:0]      w_prod;

    logic [31:0]                             w_elapsed;
    logic [23:0]                             w_div_x;
    logic [15:0]                             w_speed;
    logic signed [35:0]                      w_isum, w_lim;
    logic signed [pisc_pkg::SUM_W-1:0]       w_pterm, w_iterm;
    logic [25:0]                             w_uq;
    logic [pisc_pkg::DRIVE_W-1:0]            w_u;
    logic                                    w_run;

    pisc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pisc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_elapsed = r_now - r_next_due;
    assign w_div_x   = w_prod[33:10];
    assign w_speed   = r_sat ? 16'hFFFF : w_prod[39:24];
    assign w_lim     = signed'({10'd0, w_cfg.iterm_limit, 16'd0});
    assign w_isum    = 36'(r_integ) + 36'(signed'(w_prod[33:0]));
    assign w_pterm   = signed'({w_prod[33], w_prod[33:0], 8'd0});
    assign w_iterm   = 43'(r_integ_new);
    assign w_uq      = r_sum[41:16];
    assign w_u       = r_sum[42] ? '0
                     : (w_uq > 26'(w_cfg.pwm_max)) ? w_cfg.pwm_max : w_uq[9:0];
    assign w_run     = r_target[14:0] > 15'(w_cfg.stop_threshold);

    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            pisc_pkg::S_MUL_SPD: begin
                w_mul_en = 1'b1;
                w_mul_a  = signed'({6'd0, r_rpm});
                w_mul_b  = signed'({4'd0, w_cfg.wheel_circ_q8});
            end
            pisc_pkg::S_MUL_DIV: begin
                w_mul_en = 1'b1;
                w_mul_a  = signed'({2'd0, w_div_x[19:0]});
                w_mul_b  = signed'({1'b0, pisc_pkg::DIV15_RECIP});
            end
            pisc_pkg::S_MUL_KI: begin
                w_mul_en = 1'b1;
                w_mul_a  = signed'({6'd0, w_cfg.ki_dt_q16});
                w_mul_b  = 22'(r_err);
            end
            pisc_pkg::S_MUL_KP: begin
                w_mul_en = 1'b1;
                w_mul_a  = signed'({6'd0, w_cfg.kp_q8});
                w_mul_b  = 22'(r_err);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_now         = r_now;
        n_target      = r_target;
        n_rpm         = r_rpm;
        n_next_due    = r_next_due;
        n_integ       = r_integ;
        n_integ_new   = r_integ_new;
        n_last_speed  = r_last_speed;
        n_last_drive  = r_last_drive;
        n_sat         = r_sat;
        n_err         = r_err;
        n_sum         = r_sum;
        n_written     = r_written;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_speed   = r_out_speed;
        n_out_drive   = r_out_drive;
        n_out_written = r_out_written;
        case (r_state)
            pisc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_func   = i_func;
                    n_now    = i_now_ms;
                    n_target = i_target_speed_mm_s;
                    n_rpm    = i_wheel_rpm;
                    n_state  = pisc_pkg::S_CHECK;
                end
            end
            pisc_pkg::S_CHECK: begin
                n_written = 1'b0;
                if (r_func) begin
                    n_integ      = '0;
                    n_last_drive = '0;
                    n_state      = pisc_pkg::S_EMIT;
                end else if (w_elapsed < 32'(w_cfg.period_ms)) begin
                    n_state = pisc_pkg::S_EMIT;
                end else begin
                    n_next_due = r_next_due + 32'(w_cfg.period_ms);
                    n_state    = r_target[15] ? pisc_pkg::S_EMIT : pisc_pkg::S_MUL_SPD;
                end
            end
            pisc_pkg::S_MUL_SPD: begin
                n_state = pisc_pkg::S_MUL_DIV;
            end
            pisc_pkg::S_MUL_DIV: begin
                n_sat   = w_div_x >= pisc_pkg::SPEED_SAT_X;
                n_state = pisc_pkg::S_SPEED;
            end
            pisc_pkg::S_SPEED: begin
                n_last_speed = w_speed;
                n_err        = signed'({2'd0, r_target}) - signed'({2'd0, w_speed});
                n_state      = pisc_pkg::S_MUL_KI;
            end
            pisc_pkg::S_MUL_KI: begin
                n_state = pisc_pkg::S_MUL_KP;
            end
            pisc_pkg::S_MUL_KP: begin
                if (w_isum > w_lim) begin
                    n_integ_new = 28'(w_lim);
                end else if (w_isum < -w_lim) begin
                    n_integ_new = 28'(-w_lim);
                end else begin
                    n_integ_new = 28'(w_isum);
                end
                n_state = pisc_pkg::S_SUM;
            end
            pisc_pkg::S_SUM: begin
                n_sum   = w_pterm + w_iterm;
                n_state = pisc_pkg::S_FINISH;
            end
            pisc_pkg::S_FINISH: begin
                if (w_run) begin
                    n_integ      = r_integ_new;
                    n_last_drive = (w_u != '0 && w_u < w_cfg.stall_floor)
                                 ? w_cfg.stall_floor : w_u;
                end else begin
                    n_integ      = '0;
                    n_last_drive = '0;
                end
                n_written = 1'b1;
                n_state   = pisc_pkg::S_EMIT;
            end
            pisc_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_speed   = r_last_speed;
                    n_out_drive   = r_last_drive;
                    n_out_written = r_written;
                    n_state       = pisc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pisc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pisc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_due   <= '0;
            r_integ      <= '0;
            r_last_speed <= '0;
            r_last_drive <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_next_due   <= n_next_due;
            r_integ      <= n_integ;
            r_last_speed <= n_last_speed;
            r_last_drive <= n_last_drive;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_now         <= n_now;
        r_target      <= n_target;
        r_rpm         <= n_rpm;
        r_integ_new   <= n_integ_new;
        r_sat         <= n_sat;
        r_err         <= n_err;
        r_sum         <= n_sum;
        r_written     <= n_written;
        r_out_speed   <= n_out_speed;
        r_out_drive   <= n_out_drive;
        r_out_written <= n_out_written;
    end

    assign o_in_stall            = r_state != pisc_pkg::S_IDLE;
    assign o_out_valid           = r_out_valid;
    assign o_measured_speed_mm_s = r_out_speed;
    assign o_drive_pwm           = PWM_BITS'(r_out_drive);
    assign o_drive_written       = r_out_written;
    assign o_cfg_ready           = 1'b1;

endmodule

### rtl/pisc_chk.sv
// ============================================================================
// pisc_chk: port-level checker for the PI speed controller
// Watches the top-level ports for reset, sequencing and output hold behavior.
// ============================================================================
module pisc_chk #(
    parameter int PWM_BITS = pisc_pkg::PWM_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               i_func,
    input logic [31:0]                        i_now_ms,
    input logic signed [15:0]                 i_target_speed_mm_s,
    input logic [15:0]                        i_wheel_rpm,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [15:0]                        o_measured_speed_mm_s,
    input logic [PWM_BITS-1:0]                o_drive_pwm,
    input logic                               o_drive_written,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [pisc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [pisc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // After reset the output register is empty and the input side is open.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall set after reset");

    // A transfer in closes the input side while the sample is processed.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // A new result only appears at the end of a sample's processing.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a sample in work");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_measured_speed_mm_s)
            && $stable(o_drive_pwm) && $stable(o_drive_written))
        else $error("stalled result changed or was dropped");

endmodule

bind pi_speed_controller pisc_chk #(.PWM_BITS(PWM_BITS)) u_pisc_chk (.*);

### dv/pi_speed_controller_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// pi_speed_controller_tb: self-checking testbench of the PI speed controller
// Sends directed and random samples with random idling on both channels,
// rewrites the configuration between phases, and compares each result with
// a predictor of the schedule, speed measurement and PI step.
// ============================================================================
module pi_speed_controller_tb;

    localparam longint RPM_DIVISOR   = 15360;
    localparam longint SPEED_MAX     = 65535;
    localparam longint Q16_ONE       = 65536;
    localparam longint Q8_TO_Q16     = 256;
    localparam int     ITEMS_PER_PHASE = 134;
    localparam int     DRAIN_LIMIT   = 5000;
    localparam int     SETTLE_CYCLES = 20;

    localparam pisc_pkg::t_cfg DEFAULT_CFG = '{
        kp_q8: pisc_pkg::RST_KP, ki_dt_q16: pisc_pkg::RST_KI_DT,
        iterm_limit: pisc_pkg::RST_ILIMIT, pwm_max: pisc_pkg::RST_PWM_MAX,
        stall_floor: pisc_pkg::RST_PWM_MIN, period_ms: pisc_pkg::RST_PERIOD,
        stop_threshold: pisc_pkg::RST_STOP_THR, wheel_circ_q8: pisc_pkg::RST_WHEEL_CIRC};
    localparam pisc_pkg::t_cfg MAX_CFG = '{
        kp_q8: '1, ki_dt_q16: '1, iterm_limit: '1, pwm_max: '1, stall_floor: '1,
        period_ms: '1, stop_threshold: '1, wheel_circ_q8: '1};
    localparam pisc_pkg::t_cfg ZERO_CFG = '0;

    typedef struct packed {
        logic [pisc_pkg::SPEED_W-1:0] speed;
        logic [pisc_pkg::DRIVE_W-1:0] drive;
        logic                         written;
    } t_drive_report;

    class speed_loop_scoreboard;
        pisc_pkg::t_cfg     cfg;
        logic signed [27:0] integ_q16;
        logic [31:0]        due_mark;
        logic [15:0]        speed_hold;
        logic [9:0]         drive_hold;
        t_drive_report      expected_reports[$];
        int                 errors;

        function new();
            cfg = DEFAULT_CFG;
            integ_q16 = '0;
            due_mark = '0;
            speed_hold = '0;
            drive_hold = '0;
            errors = 0;
        endfunction

        function void note_sample(logic func, logic [31:0] now, logic [15:0] target,
                                  logic [15:0] rpm);
            logic [31:0] elapsed;
            longint      tgt, spd, err, lim, acc, sum, u;

            tgt = longint'($signed(target));
            elapsed = now - due_mark;
            if (func) begin
                integ_q16 = '0;
                drive_hold = '0;
                expected_reports.push_back('{speed_hold, drive_hold, 1'b0});
                return;
            end
            if (elapsed < cfg.period_ms) begin
                expected_reports.push_back('{speed_hold, drive_hold, 1'b0});
                return;
            end
            due_mark = due_mark + cfg.period_ms;
            if (tgt < 0) begin
                expected_reports.push_back('{speed_hold, drive_hold, 1'b0});
                return;
            end
            spd = (longint'(rpm) * longint'(cfg.wheel_circ_q8)) / RPM_DIVISOR;
            if (spd > SPEED_MAX) begin
                spd = SPEED_MAX;
            end
            err = tgt - spd;
            lim = longint'(cfg.iterm_limit) * Q16_ONE;
            acc = longint'(integ_q16) + longint'(cfg.ki_dt_q16) * err;
            if (acc > lim) begin
                acc = lim;
            end
            if (acc < -lim) begin
                acc = -lim;
            end
            sum = longint'(cfg.kp_q8) * err * Q8_TO_Q16 + acc;
            if (sum < 0) begin
                u = 0;
            end else begin
                u = sum / Q16_ONE;
                if (u > longint'(cfg.pwm_max)) begin
                    u = longint'(cfg.pwm_max);
                end
            end
            if (tgt > longint'(cfg.stop_threshold)) begin
                if (u > 0 && u < longint'(cfg.stall_floor)) begin
                    u = longint'(cfg.stall_floor);
                end
            end else begin
                acc = 0;
                u = 0;
            end
            integ_q16 = acc[27:0];
            speed_hold = spd[15:0];
            drive_hold = u[9:0];
            expected_reports.push_back('{speed_hold, drive_hold, 1'b1});
        endfunction

        function void check_report(t_drive_report got);
            t_drive_report want;

            if (expected_reports.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.speed !== want.speed) begin
                $display("%0t ns: measured_speed_mm_s mismatch, expected %0d, actual %0d",
                         $time, want.speed, got.speed);
                errors++;
            end
            if (got.drive !== want.drive) begin
                $display("%0t ns: drive_pwm mismatch, expected %0d, actual %0d",
                         $time, want.drive, got.drive);
                errors++;
            end
            if (got.written !== want.written) begin
                $display("%0t ns: drive_written mismatch, expected %0d, actual %0d",
                         $time, want.written, got.written);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic                                i_func;
    logic [31:0]                         i_now_ms;
    logic signed [15:0]                  i_target_speed_mm_s;
    logic [15:0]                         i_wheel_rpm;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic [15:0]                         o_measured_speed_mm_s;
    logic [pisc_pkg::DRIVE_W-1:0]        o_drive_pwm;
    logic                                o_drive_written;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [pisc_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [pisc_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    speed_loop_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;

    pi_speed_controller i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_func                (i_func),
        .i_now_ms              (i_now_ms),
        .i_target_speed_mm_s   (i_target_speed_mm_s),
        .i_wheel_rpm           (i_wheel_rpm),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_measured_speed_mm_s (o_measured_speed_mm_s),
        .o_drive_pwm           (o_drive_pwm),
        .o_drive_written       (o_drive_written),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_report('{o_measured_speed_mm_s, o_drive_pwm, o_drive_written});
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_sample(i_func, i_now_ms, i_target_speed_mm_s, i_wheel_rpm);
            end
        end
    end

    task automatic send_sample(logic func, logic [31:0] now, logic [15:0] target,
                               logic [15:0] rpm);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_now_ms <= now;
        i_target_speed_mm_s <= target;
        i_wheel_rpm <= rpm;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_config(pisc_pkg::t_cfg c);
        pisc_pkg::t_cfg_idx              idx;
        logic [pisc_pkg::CFG_DATA_W-1:0] data;

        idx = idx.first();
        do begin
            case (idx)
                pisc_pkg::CFG_KP:         data = pisc_pkg::CFG_DATA_W'(c.kp_q8);
                pisc_pkg::CFG_KI_DT:      data = pisc_pkg::CFG_DATA_W'(c.ki_dt_q16);
                pisc_pkg::CFG_ILIMIT:     data = pisc_pkg::CFG_DATA_W'(c.iterm_limit);
                pisc_pkg::CFG_PWM_MAX:    data = pisc_pkg::CFG_DATA_W'(c.pwm_max);
                pisc_pkg::CFG_PWM_MIN:    data = pisc_pkg::CFG_DATA_W'(c.stall_floor);
                pisc_pkg::CFG_PERIOD:     data = pisc_pkg::CFG_DATA_W'(c.period_ms);
                pisc_pkg::CFG_STOP_THR:   data = pisc_pkg::CFG_DATA_W'(c.stop_threshold);
                pisc_pkg::CFG_WHEEL_CIRC: data = pisc_pkg::CFG_DATA_W'(c.wheel_circ_q8);
                default:                  data = '0;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_valid <= 1'b0;
        sb.cfg = c;
    endtask

    function automatic pisc_pkg::t_cfg random_config();
        pisc_pkg::t_cfg c;

        c.kp_q8 = 16'($urandom_range(0, 3000));
        c.ki_dt_q16 = 16'($urandom_range(0, 8000));
        c.iterm_limit = 10'($urandom_range(0, 1023));
        c.pwm_max = 10'($urandom_range(0, 1023));
        c.stall_floor = 10'($urandom_range(0, 500));
        c.period_ms = 10'($urandom_range(1, 60));
        c.stop_threshold = 10'($urandom_range(0, 200));
        c.wheel_circ_q8 = 18'($urandom_range(8000, 80000));
        return c;
    endfunction

    task automatic run_random(int count);
        logic [31:0] clock_ms;
        logic [31:0] now;
        logic [15:0] target;
        logic [15:0] rpm;
        logic        func;
        int          per;
        int          pick;

        per = sb.cfg.period_ms;
        clock_ms = sb.due_mark + $urandom_range(0, per);
        repeat (count) begin
            pick = $urandom_range(99);
            func = 1'b0;
            rpm = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
            clock_ms = clock_ms + $urandom_range(0, per + per / 2 + 1);
            now = clock_ms;
            if (pick < 8) begin
                target = 16'($urandom_range(32768, 65535));
            end else if (pick < 22) begin
                target = 16'($urandom_range(0, sb.cfg.stop_threshold + 2));
            end else if (pick < 27) begin
                target = 16'($urandom_range(0, 32767));
            end else begin
                target = 16'($urandom_range(0, 3000));
            end
            pick = $urandom_range(99);
            if (pick < 6) begin
                func = 1'b1;
            end else if (pick < 12) begin
                now = $urandom;
                target = 16'($urandom);
                rpm = 16'($urandom);
            end
            send_sample(func, now, target, rpm);
        end
    endtask

    initial begin
        pisc_pkg::t_cfg c;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = 1'b0;
        i_now_ms = '0;
        i_target_speed_mm_s = '0;
        i_wheel_rpm = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_idle_pct = 21;
        recv_stall_pct = 85;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_sample(1'b1, 32'd0, 16'd0, 16'd0);
        send_sample(1'b0, 32'd0, 16'd500, 16'd100);
        send_sample(1'b0, 32'd20, 16'd500, 16'd100);
        send_sample(1'b0, 32'd25, 16'd500, 16'd100);
        send_sample(1'b0, 32'd40, 16'hFFFF, 16'd100);
        send_sample(1'b0, 32'd60, 16'd5, 16'd50);
        send_sample(1'b0, 32'd80, 16'h7FFF, 16'd0);
        send_sample(1'b0, 32'd100, 16'h7FFF, 16'd0);
        wait_drained();
        c = DEFAULT_CFG;
        c.iterm_limit = 10'd10;
        write_config(c);
        send_sample(1'b0, 32'd120, 16'd300, 16'd0);
        send_sample(1'b0, 32'd140, 16'h7FFF, 16'hFFFF);
        send_sample(1'b1, 32'hFFFF_FFFF, 16'h8000, 16'hFFFF);
        send_sample(1'b0, 32'd160, 16'd20, 16'd0);
        send_sample(1'b0, 32'd180, 16'h8000, 16'd0);
        send_sample(1'b0, 32'hFFFF_FFFF, 16'd1000, 16'hFFFF);
        send_sample(1'b0, 32'd50, 16'd100, 16'd10);
        wait_drained();
        c.period_ms = '0;
        write_config(c);
        send_sample(1'b0, 32'd7, 16'd200, 16'd20);
        send_sample(1'b0, 32'd7, 16'd200, 16'd20);

        for (int ph = 0; ph < 9; ph++) begin
            wait_drained();
            if (ph == 3) begin
                send_idle_pct = 85;
                recv_stall_pct = 21;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            case (ph)
                0, 7:    write_config(MAX_CFG);
                2:       write_config(ZERO_CFG);
                4:       write_config(DEFAULT_CFG);
                default: write_config(random_config());
            endcase
            run_random(ITEMS_PER_PHASE);
        end

        i_in_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && sb.expected_reports.size() != 0; w++) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.expected_reports.size() != 0) begin
            $display("%0t ns: missing results, expected %0d more, actual 0",
                     $time, sb.expected_reports.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("** pi_speed_controller: PASSED **");
        end else begin
            $display("** pi_speed_controller: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** pi_speed_controller: FAILED **");
        $finish;
    end

endmodule
